// ===== hdl/jadir_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick direction events package
// Widths, constants, register indexes and shared types of the block.
// ----------------------------------------------------------------------------
package jadir_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int KEY_W          = 4;
  localparam int DZ_W           = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 8;
  localparam int WINDOW_DEFAULT = 5;

  // Divider: the dividend is the window sum, at most 16 * 4095 and so
  // below 2^16, and the divisor is the fill count, at most 16.
  localparam int DIV_NW = 16;
  localparam int DIV_DW = 5;

  // Scaling: 255 * |avg - 2047| is at most 255 * 2048, below 2^19. As 2047 is
  // 2^11 - 1, the quotient by it is (x + (x >> 11) + 1) >> 11 for such x.
  localparam int SCALE_W      = 19;
  localparam int CENTER_SHIFT = 11;

  localparam logic [SAMPLE_W-1:0] CENTER         = 12'd2047;
  localparam logic [DZ_W-1:0]     DEADZONE_RESET = 8'd80;

  localparam logic [KEY_W-1:0] KEY_POS_X = 4'd6;
  localparam logic [KEY_W-1:0] KEY_NEG_X = 4'd7;
  localparam logic [KEY_W-1:0] KEY_POS_Y = 4'd8;
  localparam logic [KEY_W-1:0] KEY_NEG_Y = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/jadir_if.sv =====
// ----------------------------------------------------------------------------
// Joystick direction events channels
// Valid/ready channels for ADC samples and for direction key events.
// ----------------------------------------------------------------------------
interface jadir_sample_if
  import jadir_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface jadir_event_if
  import jadir_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;
  logic             pressed;
  logic             last;

  modport source (output valid, output key_code, output pressed, output last, input ready);
  modport sink   (input valid, input key_code, input pressed, input last, output ready);
endinterface

// ===== hdl/joystick_axis_to_direction_events_unit.sv =====
// ----------------------------------------------------------------------------
// Joystick axis to direction events
// Averages joystick ADC samples and turns them into key press/release events.
// ----------------------------------------------------------------------------
// Usage: each request on in_ch carries one 12-bit ADC sample. The block adds
// it to a moving window of the latest WINDOW samples, divides the window sum
// by the number of samples held, centers the average at 2047, scales it to
// -255..255 and compares it with the dead zone. It then sends zero, one or
// two key event requests on out_ch; the last one of a sample has last set.
// Configuration writes (axis_select at index 0, deadzone at index 1) take
// effect at the clock edge where cfg_we_i is high.
// One sample is handled at a time. The window sum is divided by the fill
// count on a restoring divider that retires one quotient bit per cycle over
// 16 bits; the division by 2047 is then an add and a shift, since 2047 is
// one less than a power of two. The first event is shown after the LOAD,
// AVG and SCALE states. A sample without events frees in_ch from SCALE;
// otherwise in_ch is ready again in the cycle after the last event is taken.
// When the receiver stalls, the pending event is held unchanged on out_ch
// and no new sample is accepted. Reset clears the window, the held keys and
// sets axis_select to 0 and deadzone to 80.
module joystick_axis_to_direction_events_unit
  import jadir_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  jadir_sample_if.sink          in_ch,
  jadir_event_if.source         out_ch
);

  localparam int SUM_W = $clog2(WINDOW * 4095 + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_AVG   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } seq_state_e;

  seq_state_e state_q, state_d;

  // Configuration registers.
  logic            axis_q;
  logic [DZ_W-1:0] dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 1'b0;
      dz_q   <= DEADZONE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_AXIS_SELECT: axis_q <= cfg_data_i[0];
        REG_DEADZONE:    dz_q   <= cfg_data_i[DZ_W-1:0];
        default:         ;
      endcase
    end
  end

  // Sample window: the sample enters at acceptance, and the updated sum and
  // count are ready for the divider in the following cycle.
  logic             in_accept;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_cnt;

  assign in_ch.ready = state_q == ST_IDLE;
  assign in_accept   = in_ch.valid && in_ch.ready;

  jadir_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_accept),
    .sample_i (in_ch.sample),
    .sum_o    (win_sum),
    .count_o  (win_cnt)
  );

  // Scaling: the average is at most 4095, so its distance from the center
  // is at most 2048. The product 255 * |avg - 2047| is formed as a shift and
  // a subtract and registered when the average is ready; its sign is kept
  // aside to pick the direction after the dead zone compare.
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [SAMPLE_W-1:0]  avg;
  logic [SAMPLE_W:0]    diff;
  logic                 diff_neg;
  logic [SAMPLE_W-1:0]  diff_mag;
  logic [SCALE_W-1:0]   prod;
  logic [SCALE_W-1:0]   prod_q;
  logic                 neg_q;

  always_comb begin
    avg      = div_rsp.quotient[SAMPLE_W-1:0];
    diff     = {1'b0, avg} - {1'b0, CENTER};
    diff_neg = diff[SAMPLE_W];
    diff_mag = diff_neg ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    prod     = (SCALE_W'(diff_mag) << 8) - SCALE_W'(diff_mag);
  end

  // The divider takes sum / count once per sample.
  always_comb begin
    div_req.start    = state_q == ST_LOAD;
    div_req.dividend = DIV_NW'(win_sum);
    div_req.divisor  = DIV_DW'(win_cnt);
  end

  jadir_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Event decision. The scaled magnitude is the registered product divided
  // by 2047 with truncation, done as an add and a shift. The scaled value is
  // beyond the dead zone when its magnitude exceeds deadzone; the sign then
  // picks the direction. A zero magnitude always falls in the dead region.
  logic             pos_held_q, neg_held_q;
  logic             pos_held_d, neg_held_d;
  logic [KEY_W-1:0] key_pos, key_neg;
  logic [SCALE_W:0] scale_sum;
  logic [DZ_W-1:0]  scaled_mag;
  logic             beyond;
  logic [KEY_W-1:0] ev_key_d [2];
  logic             ev_prs_d [2];
  logic [1:0]       ev_n_d;
  logic [KEY_W-1:0] ev_key_q [2];
  logic             ev_prs_q [2];
  logic [1:0]       ev_n_q;
  logic             idx_q;

  always_comb begin
    key_pos    = axis_q ? KEY_POS_Y : KEY_POS_X;
    key_neg    = axis_q ? KEY_NEG_Y : KEY_NEG_X;
    scale_sum  = {1'b0, prod_q}
               + {{(CENTER_SHIFT + 1){1'b0}}, prod_q[SCALE_W-1:CENTER_SHIFT]}
               + (SCALE_W + 1)'(1);
    scaled_mag = scale_sum[CENTER_SHIFT +: DZ_W];
    beyond     = scaled_mag > dz_q;
    pos_held_d = pos_held_q;
    neg_held_d = neg_held_q;
    ev_key_d   = '{default: '0};
    ev_prs_d   = '{default: 1'b0};
    ev_n_d     = 2'd0;
    if (beyond && !neg_q) begin
      if (!pos_held_q) begin
        ev_key_d[ev_n_d[0]] = key_pos;
        ev_prs_d[ev_n_d[0]] = 1'b1;
        ev_n_d              = ev_n_d + 2'd1;
        pos_held_d          = 1'b1;
      end
      if (neg_held_q) begin
        ev_key_d[ev_n_d[0]] = key_neg;
        ev_n_d              = ev_n_d + 2'd1;
        neg_held_d          = 1'b0;
      end
    end else if (beyond && neg_q) begin
      if (!neg_held_q) begin
        ev_key_d[ev_n_d[0]] = key_neg;
        ev_prs_d[ev_n_d[0]] = 1'b1;
        ev_n_d              = ev_n_d + 2'd1;
        neg_held_d          = 1'b1;
      end
      if (pos_held_q) begin
        ev_key_d[ev_n_d[0]] = key_pos;
        ev_n_d              = ev_n_d + 2'd1;
        pos_held_d          = 1'b0;
      end
    end else begin
      if (pos_held_q) begin
        ev_key_d[ev_n_d[0]] = key_pos;
        ev_n_d              = ev_n_d + 2'd1;
        pos_held_d          = 1'b0;
      end
      if (neg_held_q) begin
        ev_key_d[ev_n_d[0]] = key_neg;
        ev_n_d              = ev_n_d + 2'd1;
        neg_held_d          = 1'b0;
      end
    end
  end

  // Sequencer.
  logic out_accept;
  assign out_accept = out_ch.valid && out_ch.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_AVG;
      ST_AVG:   if (div_rsp.done) state_d = ST_SCALE;
      ST_SCALE: state_d = (ev_n_d == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:  if (out_accept && out_ch.last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_held_q <= 1'b0;
      neg_held_q <= 1'b0;
      neg_q      <= 1'b0;
      ev_n_q     <= 2'd0;
      idx_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_AVG && div_rsp.done) begin
        neg_q <= diff_neg;
      end
      if (state_q == ST_SCALE) begin
        pos_held_q <= pos_held_d;
        neg_held_q <= neg_held_d;
        ev_n_q     <= ev_n_d;
        idx_q      <= 1'b0;
      end else if (out_accept) begin
        idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_AVG && div_rsp.done) begin
      prod_q <= prod;
    end
    if (state_q == ST_SCALE) begin
      ev_key_q <= ev_key_d;
      ev_prs_q <= ev_prs_d;
    end
  end

  assign out_ch.valid    = state_q == ST_EMIT;
  assign out_ch.key_code = ev_key_q[idx_q];
  assign out_ch.pressed  = ev_prs_q[idx_q];
  assign out_ch.last     = idx_q || (ev_n_q == 2'd1);

`ifndef SYNTHESIS
  // A sample is never taken while an event of the previous one is pending.
  a_no_accept_while_emitting: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_ch.ready |-> !out_ch.valid
  ) else $error("input ready while an event is pending");

  // A taken sample keeps the input closed for the following cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_accept |=> !in_ch.ready
  ) else $error("input ready right after a sample was taken");

  // A first event that is not the last one is followed by a second event.
  a_second_event_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_accept && !out_ch.last) |=> (out_ch.valid && out_ch.last)
  ) else $error("second event of a sample missing");

  // Both directions of one axis are never held at once.
  a_exclusive_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(pos_held_q && neg_held_q)
  ) else $error("both direction keys held");
`endif

endmodule

// ===== hdl/jadir_divider.sv =====
// ----------------------------------------------------------------------------
// Joystick direction events divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jadir_divider
  import jadir_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, divisor_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  logic [DIV_DW:0]   shifted, trial;
  logic              fits;

  // The next dividend bit enters from the top of the quotient register.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_NW-1]};
    trial   = shifted - {1'b0, divisor_q};
    fits    = shifted >= {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], fits};
      rem_q <= fits ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/jadir_window.sv =====
// ----------------------------------------------------------------------------
// Joystick direction events sample window
// Ring of the latest samples with its running sum and fill count.
// ----------------------------------------------------------------------------
module jadir_window
  import jadir_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  logic [SAMPLE_W-1:0]                     sample_i,
  output logic [$clog2(WINDOW*4095+1)-1:0]        sum_o,
  output logic [$clog2(WINDOW+1)-1:0]             count_o
);

  localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SAMPLE_W-1:0] ring_q [WINDOW];
  logic [SLOT_W-1:0]   slot_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    sum_q;

  logic                full;
  logic [SUM_W-1:0]    evicted;

  // Once the ring is full, the slot about to be overwritten leaves the sum.
  always_comb begin
    full    = cnt_q == CNT_W'(WINDOW);
    evicted = full ? SUM_W'(ring_q[slot_q]) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
    end else if (push_i) begin
      sum_q  <= sum_q - evicted + SUM_W'(sample_i);
      slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      if (!full) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ring_q[slot_q] <= sample_i;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = cnt_q;

endmodule

// ===== verif/joystick_axis_to_direction_events_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick direction events unit test
// Drives ADC sample requests through the block, predicts the key press and
// release events of every sample, and checks each event request in order.
// ----------------------------------------------------------------------------
module joystick_axis_to_direction_events_unit_test;
  import jadir_pkg::*;

  // Scaling of the centered average, and the timing of the run.
  localparam int FULL_SCALE     = 255;
  localparam int SETTLE_CYCLES  = 50;      // pause after the last expected event
  localparam int BACKLOG_CYCLES = 400;     // long receiver hold-off
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_ITEMS  = 185;
  localparam int RUN_LIMIT_NS   = 8000000; // several times the slowest run
  localparam int REPORT_CAP     = 100;

  // One direction key event, in the order of the output request fields.
  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             pressed;
    logic             last;
  } key_event_t;

  localparam key_event_t NO_EVENT = '0;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One line of the directed stimulus. A sample row may carry its expected
  // event typed in by hand; every sample row still goes through the predictor.
  typedef struct packed {
    row_kind_e             kind;
    logic [SAMPLE_W-1:0]   sample;
    logic                  typed;
    logic [1:0]            typed_count;
    key_event_t            typed_event;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 29;

  // The directed walk starts from reset (X axis, dead zone 80). It presses and
  // releases the positive key, fills the window with zeros to press the
  // negative key, then with a zero dead zone swings straight from one side to
  // the other so that a press and a release come from one sample. The axis is
  // switched while the negative key is held, the full dead zone leaves only a
  // release, and an axis write with its upper bits set must select X again.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{ROW_SAMPLE, 12'd4095, 1'b1, 2'd1, '{KEY_POS_X, 1'b1, 1'b1}, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b1, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_WRITE,  12'd0,    1'b0, 2'd0, NO_EVENT, REG_DEADZONE,    8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_WRITE,  12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd1},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_WRITE,  12'd0,    1'b0, 2'd0, NO_EVENT, REG_DEADZONE,    8'd255},
    '{ROW_SAMPLE, 12'd2047, 1'b1, 2'd1, '{KEY_POS_Y, 1'b0, 1'b1}, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b1, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_WRITE,  12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'hFE},
    '{ROW_WRITE,  12'd0,    1'b0, 2'd0, NO_EVENT, REG_DEADZONE,    DEADZONE_RESET},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd0,    1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd2047, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd2047, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0},
    '{ROW_SAMPLE, 12'd4095, 1'b0, 2'd0, NO_EVENT, REG_AXIS_SELECT, 8'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  jadir_sample_if sample_ch ();
  jadir_event_if  event_ch ();

  joystick_axis_to_direction_events_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (sample_ch),
    .out_ch      (event_ch)
  );

  always #6 clk_i = ~clk_i;

  // Side band that travels with the sample request, so that the monitor sees
  // the typed expectation that belongs to the sample it accepts.
  logic       row_typed;
  logic [1:0] row_typed_count;
  key_event_t row_typed_event;

  // Idle rates in percent for the sample sender and the event receiver.
  int send_idle_pct = 22;
  int recv_idle_pct = 54;

  // Set once by the stimulus; the receiver then holds off by itself.
  logic backlog_armed = 1'b0;
  logic backlog_done  = 1'b0;

  // Predictor copy of the configuration and of the averaging state.
  logic                cfg_axis     = 1'b0;
  logic [DZ_W-1:0]     cfg_deadzone = DEADZONE_RESET;
  logic [SAMPLE_W-1:0] ring_samples [WINDOW_DEFAULT] = '{default: '0};
  logic [2:0]          ring_slot     = '0;
  logic [2:0]          ring_fill     = '0;
  logic [14:0]         ring_sum      = '0;
  logic                positive_down = 1'b0;
  logic                negative_down = 1'b0;

  key_event_t awaited_events [$];
  int         mismatch_count = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("%0t ns: MISMATCH %s", $time, what);
    end
  endtask

  // Takes one sample into the moving window, derives the scaled position and
  // returns the key events it causes, updating the held-key flags.
  function automatic void predict_key_events(input logic [SAMPLE_W-1:0] s,
                                             output key_event_t evs [2],
                                             output int count);
    logic [2:0]       slot;
    int               avg;
    int               scaled;
    int               dz;
    logic [KEY_W-1:0] key_pos;
    logic [KEY_W-1:0] key_neg;
    slot = (int'(ring_slot) >= WINDOW_DEFAULT) ? 3'd0 : ring_slot;
    if (int'(ring_fill) >= WINDOW_DEFAULT) begin
      ring_sum = ring_sum - 15'(ring_samples[slot]);
    end
    ring_samples[slot] = s;
    ring_sum = ring_sum + 15'(s);
    ring_slot = (int'(slot) + 1 >= WINDOW_DEFAULT) ? 3'd0 : slot + 3'd1;
    if (int'(ring_fill) < WINDOW_DEFAULT) begin
      ring_fill = ring_fill + 3'd1;
    end
    avg = int'(ring_sum) / int'(ring_fill);
    // Signed integer division in SystemVerilog truncates toward zero.
    scaled = (FULL_SCALE * (avg - int'(CENTER))) / int'(CENTER);
    dz = int'(cfg_deadzone);
    key_pos = cfg_axis ? KEY_POS_Y : KEY_POS_X;
    key_neg = cfg_axis ? KEY_NEG_Y : KEY_NEG_X;
    count = 0;
    evs[0] = NO_EVENT;
    evs[1] = NO_EVENT;
    if (scaled > dz) begin
      if (!positive_down) begin
        evs[count] = '{key_pos, 1'b1, 1'b0};
        count++;
        positive_down = 1'b1;
      end
      if (negative_down) begin
        evs[count] = '{key_neg, 1'b0, 1'b0};
        count++;
        negative_down = 1'b0;
      end
    end else if (scaled < -dz) begin
      if (!negative_down) begin
        evs[count] = '{key_neg, 1'b1, 1'b0};
        count++;
        negative_down = 1'b1;
      end
      if (positive_down) begin
        evs[count] = '{key_pos, 1'b0, 1'b0};
        count++;
        positive_down = 1'b0;
      end
    end else begin
      if (positive_down) begin
        evs[count] = '{key_pos, 1'b0, 1'b0};
        count++;
        positive_down = 1'b0;
      end
      if (negative_down) begin
        evs[count] = '{key_neg, 1'b0, 1'b0};
        count++;
        negative_down = 1'b0;
      end
    end
    if (count > 0) begin
      evs[count-1].last = 1'b1;
    end
  endfunction

  // One process watches the configuration port and both channels, so the
  // order of prediction and checking is fixed where they coincide: register
  // writes first, then accepted samples, then accepted events.
  always @(posedge clk_i) begin : request_monitor
    key_event_t evs [2];
    key_event_t want;
    int         count;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_AXIS_SELECT: cfg_axis = cfg_data_i[0];
          REG_DEADZONE:    cfg_deadzone = cfg_data_i[DZ_W-1:0];
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        // The predictor always runs so that its state follows the block;
        // a typed row replaces only what is expected on the output.
        predict_key_events(sample_ch.sample, evs, count);
        if (row_typed) begin
          count = int'(row_typed_count);
          evs[0] = row_typed_event;
        end
        for (int k = 0; k < count; k++) begin
          awaited_events.push_back(evs[k]);
        end
      end
      if (event_ch.valid && event_ch.ready) begin
        if (awaited_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event key %0d pressed %0b last %0b",
                                    event_ch.key_code, event_ch.pressed, event_ch.last));
        end else begin
          want = awaited_events.pop_front();
          if (event_ch.key_code !== want.key_code) begin
            report_mismatch($sformatf("key_code %0d, expected %0d",
                                      event_ch.key_code, want.key_code));
          end
          if (event_ch.pressed !== want.pressed) begin
            report_mismatch($sformatf("pressed %0b, expected %0b (key %0d)",
                                      event_ch.pressed, want.pressed, want.key_code));
          end
          if (event_ch.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (key %0d)",
                                      event_ch.last, want.last, want.key_code));
          end
        end
      end
    end
  end

  // Event receiver. It stalls at random at the current rate. Once the
  // backlog is armed it holds ready low for a long stretch that it counts
  // itself, while the sender keeps offering samples, so the block has to
  // hold its pending event and stop taking new sample requests.
  initial begin
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (backlog_armed && !backlog_done) begin
        event_ch.ready <= 1'b0;
        for (int c = 1; c < BACKLOG_CYCLES; c++) begin
          @(posedge clk_i);
        end
        backlog_done = 1'b1;
      end else begin
        event_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one sample request, after a random number of idle cycles, and
  // returns at the edge where it is accepted. Valid stays high when the next
  // request follows without a gap.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                              input logic [1:0] typed_count, input key_event_t typed_ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    row_typed        <= typed;
    row_typed_count  <= typed_count;
    row_typed_event  <= typed_ev;
    do @(posedge clk_i); while (sample_ch.ready !== 1'b1);
  endtask

  // Stops sending and waits until every expected event has come. A sample
  // that causes no event may still be in the divider, so a pause longer than
  // one sample time follows before the block is taken as idle.
  task automatic settle_block();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int                    produced;
    int                    target;
    int                    run_len;
    int                    level;
    logic [CFG_DATA_W-1:0] dz_pick;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= REG_AXIS_SELECT;
    cfg_data_i       <= '0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    row_typed        <= 1'b0;
    row_typed_count  <= 2'd0;
    row_typed_event  <= NO_EVENT;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        program_register(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].reg_data);
      end else begin
        offer_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed,
                     DIRECTED_ROWS[i].typed_count, DIRECTED_ROWS[i].typed_event);
      end
    end

    // Random part in segments, each with its own axis and dead zone. The
    // first two segments idle mostly on the receiver side, the next two
    // mostly on the sender side, the last two not at all; the long receiver
    // hold-off falls into the last segment, where samples come back to back.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        send_idle_pct <= 54;
        recv_idle_pct <= 22;
      end else if (seg == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      // Upper data bits are random too; only bit 0 selects the axis.
      program_register(REG_AXIS_SELECT, CFG_DATA_W'($urandom_range(0, 255)));
      case ($urandom_range(0, 5))
        0:       dz_pick = 8'd0;
        1:       dz_pick = 8'd255;
        2:       dz_pick = CFG_DATA_W'($urandom_range(60, 100));
        default: dz_pick = CFG_DATA_W'($urandom_range(0, 255));
      endcase
      program_register(REG_DEADZONE, dz_pick);
      if (seg == SEGMENTS - 1) begin
        backlog_armed <= 1'b1;
      end
      produced = 0;
      while (produced < SEGMENT_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          // A held stick position: a run of samples around one level, near
          // either end, around the center, or anywhere, so the average
          // really crosses the dead zone in both directions.
          case ($urandom_range(0, 4))
            0:       target = $urandom_range(0, 400);
            1:       target = $urandom_range(3700, 4095);
            2:       target = $urandom_range(1500, 2600);
            default: target = $urandom_range(0, 4095);
          endcase
          run_len = $urandom_range(2, 8);
          for (int k = 0; k < run_len && produced < SEGMENT_ITEMS; k++) begin
            level = target + int'($urandom_range(0, 400)) - 200;
            if (level < 0) begin
              level = 0;
            end else if (level > 4095) begin
              level = 4095;
            end
            offer_sample(SAMPLE_W'(level), 1'b0, 2'd0, NO_EVENT);
            produced++;
          end
        end else begin
          // Single spike anywhere in the range.
          offer_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, 2'd0, NO_EVENT);
          produced++;
        end
      end
    end

    // Drain, then let the block sit a while so that any stray event request
    // is still caught by the monitor.
    settle_block();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TIMEOUT: requests stopped moving");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== joystick_axis_to_direction_events_unit.f =====
hdl/jadir_pkg.sv
hdl/jadir_if.sv
hdl/jadir_divider.sv
hdl/jadir_window.sv
hdl/joystick_axis_to_direction_events_unit.sv
verif/joystick_axis_to_direction_events_unit_test.sv
